// File: rtl/wuia_pkg.sv
// Shared types and constants for the wide unsigned integer ALU.
`default_nettype none

package wuia_pkg;

  localparam int LOW_W       = 64;
  localparam int HIGH_W      = 32;
  localparam int IO_W        = LOW_W + HIGH_W;
  localparam int EXT_W       = 128;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 2 * IO_W;
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * IO_W - 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic addsub;
    logic step_mul;
    logic step_div;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic div_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/wuia_dp.sv
// Datapath: operand registers, adder and subtractor, shift registers and result register.
`default_nettype none

module wuia_dp #(
  parameter int W = 96
) (
  input  wire logic                                clk,
  input  wire wuia_pkg::dp_cmd_t                   cmd,
  input  wire logic [wuia_pkg::OP_W-1:0]           in_op,
  input  wire logic [wuia_pkg::IN_TDATA_W-1:0]     in_data,
  output wuia_pkg::dp_stat_t                       stat,
  output logic      [wuia_pkg::OUT_TDATA_W-1:0]    out_data
);

  logic [wuia_pkg::EXT_W-1:0] a_ext, b_ext, res_ext, rem_ext;
  logic [W-1:0] a_in, b_in;
  logic         b_zero;
  logic         in_is_div;

  wuia_pkg::op_t op_r;
  logic [W-1:0]  a_r, b_r, src_r, res_r, rem_r;
  logic          flag_r, divz_r;
  logic [wuia_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [W:0]   sum_w, diff_w, mul_sum, div_t;
  logic [W-1:0] mul_sh, mul_add, div_rsh;
  logic         div_ge, a_lt, a_eq;

  assign a_ext     = wuia_pkg::EXT_W'(in_data[wuia_pkg::IO_W-1:0]);
  assign b_ext     = wuia_pkg::EXT_W'(in_data[2*wuia_pkg::IO_W-1:wuia_pkg::IO_W]);
  assign a_in      = a_ext[W-1:0];
  assign b_in      = b_ext[W-1:0];
  assign b_zero    = (b_in == '0);
  assign in_is_div = (in_op == wuia_pkg::OP_DIV);

  assign sum_w  = {1'b0, a_r} + {1'b0, b_r};
  assign diff_w = {1'b0, a_r} - {1'b0, b_r};

  // multiply: shift partial product, add a when the next multiplier bit is set
  assign mul_sh  = {res_r[W-2:0], 1'b0};
  assign mul_add = src_r[W-1] ? a_r : '0;
  assign mul_sum = {1'b0, mul_sh} + {1'b0, mul_add};

  // restoring divide: the bit shifted out of rem takes part in the compare
  assign div_rsh = {rem_r[W-2:0], src_r[W-1]};
  assign div_t   = {rem_r[W-1], div_rsh} - {1'b0, b_r};
  assign div_ge  = ~div_t[W];

  assign a_lt    = (a_r < b_r);
  assign a_eq    = (a_r == b_r);
  assign res_ext = wuia_pkg::EXT_W'(res_r);
  assign rem_ext = wuia_pkg::EXT_W'(rem_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= wuia_pkg::op_t'(in_op);
      a_r    <= a_in;
      b_r    <= b_in;
      src_r  <= (in_op == wuia_pkg::OP_MUL) ? b_in : a_in;
      res_r  <= '0;
      rem_r  <= (in_is_div && b_zero) ? a_in : '0;
      flag_r <= in_is_div && b_zero;
      divz_r <= b_zero;
    end else if (cmd.addsub) begin
      if (op_r == wuia_pkg::OP_ADD) begin
        res_r  <= sum_w[W-1:0];
        flag_r <= sum_w[W];
      end else begin
        res_r  <= diff_w[W-1:0];
        flag_r <= diff_w[W];
      end
    end else if (cmd.step_mul) begin
      src_r <= {src_r[W-2:0], 1'b0};
      if (!flag_r) begin
        if (res_r[W-1] || mul_sum[W]) begin
          flag_r <= 1'b1;
          res_r  <= '0;
        end else begin
          res_r <= mul_sum[W-1:0];
        end
      end
    end else if (cmd.step_div) begin
      src_r <= {src_r[W-2:0], 1'b0};
      res_r <= {res_r[W-2:0], div_ge};
      rem_r <= div_ge ? div_t[W-1:0] : div_rsh;
    end

    if (cmd.commit) begin
      out_data_r <= {{wuia_pkg::OUT_PAD_W{1'b0}}, a_eq, a_lt, flag_r,
                     rem_ext[wuia_pkg::IO_W-1:0], res_ext[wuia_pkg::IO_W-1:0]};
    end
  end

  assign stat.op       = op_r;
  assign stat.div_zero = divz_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

// File: rtl/wuia_ctrl.sv
// Controller: item handshakes, operation sequencing and bit counter.
`default_nettype none

module wuia_ctrl #(
  parameter int W = 96
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [wuia_pkg::OP_W-1:0]    in_op,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  input  wire wuia_pkg::dp_stat_t           stat,
  output wuia_pkg::dp_cmd_t                 cmd
);

  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDSUB,
    S_ITER,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_free;
  logic             div_skip;

  assign out_free = !out_valid_r || out_tready;
  assign div_skip = (stat.op == wuia_pkg::OP_DIV) && stat.div_zero;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    cmd.addsub   = (state_r == S_ADDSUB);
    cmd.step_mul = (state_r == S_ITER) && (stat.op == wuia_pkg::OP_MUL);
    cmd.step_div = (state_r == S_ITER) && (stat.op == wuia_pkg::OP_DIV) && !stat.div_zero;
    cmd.commit   = (state_r == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cnt_r <= '0;
            if (in_op == wuia_pkg::OP_ADD || in_op == wuia_pkg::OP_SUB) begin
              state_r <= S_ADDSUB;
            end else begin
              state_r <= S_ITER;
            end
          end
        end
        S_ADDSUB: begin
          state_r <= S_FIN;
        end
        S_ITER: begin
          if (div_skip) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
            if (cnt_r == CNT_LAST) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/wide_unsigned_integer_alu.sv
// Top level of the wide unsigned integer ALU: add, subtract, multiply, divide with remainder.
// Add and subtract go through the add/subtract state and divide by zero skips the loop;
// multiply and divide run the one-bit-per-cycle shift/add loop over all MANT_BITS bits.
// One item at a time: next item accepted the cycle after the result is loaded into the
// output register; the result waits there until taken.
// rst_n (synchronous, active low) clears the controller and the output valid flag only.
`default_nettype none

module wide_unsigned_integer_alu #(
  parameter int MANT_BITS = 96
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // a_low, a_high, b_low, b_high
  input  wire logic [wuia_pkg::IN_TDATA_W-1:0]      in_tdata,
  // op
  input  wire logic [wuia_pkg::OP_W-1:0]            in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // result_low, result_high, rem_low, rem_high, flag, a_less, a_equal, zero pad
  output logic      [wuia_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  wuia_pkg::dp_cmd_t  cmd;
  wuia_pkg::dp_stat_t stat;

  wuia_ctrl #(
    .W (MANT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wuia_dp #(
    .W (MANT_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_op    (in_tuser),
    .in_data  (in_tdata),
    .stat     (stat),
    .out_data (out_tdata)
  );

  localparam int FLAG_BIT  = 2 * wuia_pkg::IO_W;
  localparam int LESS_BIT  = FLAG_BIT + 1;
  localparam int EQUAL_BIT = FLAG_BIT + 2;

  a_less_equal_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[LESS_BIT] && out_tdata[EQUAL_BIT]))
    else $error("a_less and a_equal both set");

  one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again while an item is in flight");

  commit_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("result loaded but out_tvalid low");

  commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
